// File: sv/gpmc_pkg.sv
// Package with the command codes, item types and fixed constants of the GPIO controller.
`default_nettype none
package gpmc_pkg;

  localparam int unsigned PINS_PER_PORT = 16;
  localparam int unsigned OUT_PORTS     = 4;
  localparam logic [3:0]  NIB_FLOAT     = 4'h4;
  localparam logic [3:0]  NIB_PULL      = 4'h8;
  localparam logic [63:0] MODE_RESET    = {16{NIB_FLOAT}};

  typedef enum logic [3:0] {
    FN_WNOP    = 4'd0,
    FN_CFG     = 4'd1,
    FN_SETPIN  = 4'd2,
    FN_BATCH   = 4'd3,
    FN_TOGGLE  = 4'd4,
    FN_PULL    = 4'd5,
    FN_WLATCH  = 4'd6,
    FN_RNOP    = 4'd7,
    FN_RDIN    = 4'd8,
    FN_RDBIT   = 4'd9,
    FN_RDLATCH = 4'd10
  } func_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  pin;
    logic [3:0]  nibble;
    logic [31:0] value;
    logic [31:0] reset_bits;
    logic [63:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] read_data;
    logic [3:0]  port_clocks;
    logic [63:0] latch_levels;
  } result_t;

endpackage
`default_nettype wire

// File: sv/gpmc_if.sv
// Interfaces of the command channel and the result channel.
`default_nettype none
interface gpmc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [7:0]  pin;
  logic [3:0]  nibble;
  logic [31:0] value;
  logic [31:0] reset_bits;
  logic [63:0] pin_levels;

  modport source (output valid, func, pin, nibble, value, reset_bits, pin_levels,
                  input ready);
  modport sink (input valid, func, pin, nibble, value, reset_bits, pin_levels,
                output ready);
endinterface

interface gpmc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] read_data;
  logic [3:0]  port_clocks;
  logic [63:0] latch_levels;

  modport source (output valid, accepted, read_data, port_clocks, latch_levels,
                  input ready);
  modport sink (input valid, accepted, read_data, port_clocks, latch_levels,
                output ready);
endinterface
`default_nettype wire

// File: sv/gpio_multi_port_controller_unit.sv
// Top level of the multi-port GPIO controller.
// One command beat is taken per clock cycle when the result side keeps up; each beat passes an
// input register, one read-modify-write of the addressed port (or of ports A and B for a batch
// set/reset) and a result register before its result is offered on the output channel. A result
// held back by the sink keeps the command register occupied, and the input then stalls until the
// result leaves.
// The result carries the output latches and clock enables as they stand after the command.
// Ports beyond D hold state but are not shown in the result and read their inputs as zero.
`default_nettype none
module gpio_multi_port_controller_unit
  import gpmc_pkg::*;
#(
  parameter int unsigned PORT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  gpmc_in_if.sink           in_ch,
  gpmc_out_if.source        out_ch
);

  logic                        s1_valid_r;
  item_t                       s1_item_r;
  logic                        out_valid_r;
  result_t                     out_res_r;
  logic                        commit;
  logic [PORT_COUNT-1:0][15:0] port_latch;
  logic [PORT_COUNT-1:0][63:0] port_mode;
  logic [PORT_COUNT-1:0]       port_clk_en;
  logic [PORT_COUNT-1:0][15:0] latch_nxt;
  logic [PORT_COUNT-1:0][63:0] mode_nxt;
  logic [PORT_COUNT-1:0]       clk_en_nxt;
  result_t                     res;

  assign commit      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{func: in_ch.func, pin: in_ch.pin, nibble: in_ch.nibble,
                     value: in_ch.value, reset_bits: in_ch.reset_bits,
                     pin_levels: in_ch.pin_levels};
    end
  end

  gpmc_exec #(.PORT_COUNT(PORT_COUNT)) u_exec (
    .item       (s1_item_r),
    .latch      (port_latch),
    .mode       (port_mode),
    .clk_en     (port_clk_en),
    .latch_nxt  (latch_nxt),
    .mode_nxt   (mode_nxt),
    .clk_en_nxt (clk_en_nxt),
    .res        (res)
  );

  gpmc_port_bank #(.PORT_COUNT(PORT_COUNT)) u_port_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .latch_nxt  (latch_nxt),
    .mode_nxt   (mode_nxt),
    .clk_en_nxt (clk_en_nxt),
    .latch      (port_latch),
    .mode       (port_mode),
    .clk_en     (port_clk_en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_res_r.accepted;
  assign out_ch.read_data    = out_res_r.read_data;
  assign out_ch.port_clocks  = out_res_r.port_clocks;
  assign out_ch.latch_levels = out_res_r.latch_levels;

`ifndef SYNTHESIS
  // Clock enables are only ever set, never cleared, outside reset.
  a_clk_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ((port_clk_en & $past(port_clk_en)) == $past(port_clk_en)))
    else $error("port clock enable cleared");

  // A rejected command returns no read data.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.accepted) |-> (out_ch.read_data == 16'd0))
    else $error("read data on rejected beat");

  // A held command with a stalled result blocks the input side.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while pipeline is full");

  // The latches move only when a command is committed.
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !commit) |=> $stable(port_latch))
    else $error("latch changed without a commit");
`endif

endmodule
`default_nettype wire

// File: sv/gpmc_exec.sv
// Command decode and read-modify-write of the port registers for one beat.
`default_nettype none
module gpmc_exec
  import gpmc_pkg::*;
#(
  parameter int unsigned PORT_COUNT = 4
) (
  input  item_t                          item,
  input  logic [PORT_COUNT-1:0][15:0]    latch,
  input  logic [PORT_COUNT-1:0][63:0]    mode,
  input  logic [PORT_COUNT-1:0]          clk_en,
  output logic [PORT_COUNT-1:0][15:0]    latch_nxt,
  output logic [PORT_COUNT-1:0][63:0]    mode_nxt,
  output logic [PORT_COUNT-1:0]          clk_en_nxt,
  output result_t                        res
);

  func_t       fn;
  logic [3:0]  port;
  logic [3:0]  local_pin;
  logic        port_ok;
  logic [15:0] bit_mask;
  logic [5:0]  nib_sh;
  logic [63:0] nib_mask;
  logic [15:0] in_word;
  logic [15:0] sel_latch;
  logic [15:0] set_m;
  logic [15:0] rst_m;
  logic        ok;
  logic [15:0] rd;

  always_comb begin
    fn        = func_t'(item.func);
    port      = item.pin[7:4];
    local_pin = item.pin[3:0];
    port_ok   = (32'(port) < PORT_COUNT);
    bit_mask  = 16'd1 << local_pin;
    nib_sh    = {local_pin, 2'b00};
    nib_mask  = 64'hF << nib_sh;
    in_word   = (port[3:2] == 2'b00) ? 16'(item.pin_levels >> {port[1:0], 4'b0000}) : 16'd0;
    sel_latch = 16'd0;
    latch_nxt  = latch;
    mode_nxt   = mode;
    clk_en_nxt = clk_en;
    set_m = 16'd0;
    rst_m = 16'd0;

    for (int p = 0; p < PORT_COUNT; p++) begin
      if (port == 4'(p)) begin
        sel_latch = latch[p];
      end
      if (fn == FN_BATCH && p < 2) begin
        set_m = (p == 0) ? item.value[15:0] : item.value[31:16];
        rst_m = (p == 0) ? item.reset_bits[15:0] : item.reset_bits[31:16];
        clk_en_nxt[p] = 1'b1;
        latch_nxt[p]  = (latch[p] & ~rst_m) | set_m;
      end else if (port == 4'(p)) begin
        case (fn) inside
          FN_CFG, FN_SETPIN, FN_TOGGLE, FN_PULL, FN_WLATCH, FN_RDIN, FN_RDBIT,
          FN_RDLATCH: clk_en_nxt[p] = 1'b1;
          default: ;
        endcase
        case (fn)
          FN_CFG: begin
            mode_nxt[p] = (mode[p] & ~nib_mask) | (64'(item.nibble) << nib_sh);
          end
          FN_SETPIN: begin
            latch_nxt[p] = (item.value != 32'd0) ? (latch[p] | bit_mask)
                                                 : (latch[p] & ~bit_mask);
          end
          FN_TOGGLE: begin
            latch_nxt[p] = in_word[local_pin] ? (latch[p] & ~bit_mask)
                                              : (latch[p] | bit_mask);
          end
          FN_PULL: begin
            if (item.value == 32'd0) begin
              mode_nxt[p] = (mode[p] & ~nib_mask) | (64'(NIB_FLOAT) << nib_sh);
            end else begin
              mode_nxt[p]  = (mode[p] & ~nib_mask) | (64'(NIB_PULL) << nib_sh);
              latch_nxt[p] = (item.value == 32'd1) ? (latch[p] | bit_mask)
                                                   : (latch[p] & ~bit_mask);
            end
          end
          FN_WLATCH: latch_nxt[p] = item.value[15:0];
          default: ;
        endcase
      end
    end

    ok = 1'b0;
    rd = 16'd0;
    case (fn) inside
      FN_WNOP, FN_BATCH: ok = 1'b1;
      FN_CFG, FN_SETPIN, FN_TOGGLE, FN_PULL, FN_WLATCH: ok = port_ok;
      FN_RDIN: begin
        ok = port_ok;
        rd = in_word;
      end
      FN_RDBIT: begin
        ok = port_ok;
        rd = {15'd0, in_word[local_pin]};
      end
      FN_RDLATCH: begin
        ok = port_ok;
        rd = sel_latch;
      end
      default: ok = 1'b0;
    endcase

    res.accepted     = ok;
    res.read_data    = ok ? rd : 16'd0;
    res.port_clocks  = 4'd0;
    res.latch_levels = 64'd0;
    for (int p = 0; p < PORT_COUNT && p < OUT_PORTS; p++) begin
      res.port_clocks[p]             = clk_en_nxt[p];
      res.latch_levels[p*16 +: 16]   = latch_nxt[p];
    end
  end

endmodule
`default_nettype wire

// File: sv/gpmc_port_bank.sv
// Mode words, output latches and clock-enable bits of all ports.
`default_nettype none
module gpmc_port_bank
  import gpmc_pkg::*;
#(
  parameter int unsigned PORT_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        commit,
  input  logic [PORT_COUNT-1:0][15:0] latch_nxt,
  input  logic [PORT_COUNT-1:0][63:0] mode_nxt,
  input  logic [PORT_COUNT-1:0]       clk_en_nxt,
  output logic [PORT_COUNT-1:0][15:0] latch,
  output logic [PORT_COUNT-1:0][63:0] mode,
  output logic [PORT_COUNT-1:0]       clk_en
);

  logic [PORT_COUNT-1:0][15:0] latch_r;
  logic [PORT_COUNT-1:0][63:0] mode_r;
  logic [PORT_COUNT-1:0]       clk_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= '0;
      mode_r   <= {PORT_COUNT{MODE_RESET}};
      clk_en_r <= '0;
    end else if (commit) begin
      latch_r  <= latch_nxt;
      mode_r   <= mode_nxt;
      clk_en_r <= clk_en_nxt;
    end
  end

  assign latch  = latch_r;
  assign mode   = mode_r;
  assign clk_en = clk_en_r;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the multi-port GPIO controller, with a queued driver and a monitor.
`timescale 1ns / 1ps

module testbench;
  import gpmc_pkg::*;

  localparam int unsigned PORT_COUNT   = 4;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;

  gpmc_in_if  in_ch ();
  gpmc_out_if out_ch ();

  gpio_multi_port_controller_unit #(
    .PORT_COUNT(PORT_COUNT)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  item_t       cmd_queue[$];
  result_t     expected_results[$];
  logic [63:0] mode_word[PORT_COUNT];
  logic [15:0] latch[PORT_COUNT];
  logic [PORT_COUNT-1:0] clk_en;

  int unsigned cycle_count     = 0;
  int unsigned sent_count      = 0;
  int unsigned taken_count     = 0;
  int unsigned rejected_count  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned n_directed      = 0;
  int unsigned n_total         = 0;
  logic        in_fire         = 1'b0;
  logic        hold_off        = 1'b0;
  logic        quiet;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic item_t make_cmd(logic [3:0] func, logic [7:0] pin, logic [3:0] nibble,
                                     logic [31:0] value, logic [31:0] rst_mask,
                                     logic [63:0] levels);
    item_t c;
    c.func       = func;
    c.pin        = pin;
    c.nibble     = nibble;
    c.value      = value;
    c.reset_bits = rst_mask;
    c.pin_levels = levels;
    return c;
  endfunction

  function automatic result_t predict_command(item_t c);
    int unsigned port;
    logic [3:0]  lsel;
    logic [15:0] in_word;
    logic [15:0] rd;
    logic        ok;
    result_t     r;
    port    = c.pin / PINS_PER_PORT;
    lsel    = c.pin[3:0];
    in_word = 16'(c.pin_levels >> (16 * port));
    rd      = '0;
    ok      = 1'b0;
    case (c.func)
      FN_WNOP: ok = 1'b1;
      FN_BATCH: begin
        clk_en[0] = 1'b1;
        latch[0]  = (latch[0] & ~c.reset_bits[15:0]) | c.value[15:0];
        if (PORT_COUNT > 1) begin
          clk_en[1 % PORT_COUNT] = 1'b1;
          latch[1 % PORT_COUNT]  = (latch[1 % PORT_COUNT] & ~c.reset_bits[31:16])
                                   | c.value[31:16];
        end
        ok = 1'b1;
      end
      FN_CFG, FN_SETPIN, FN_TOGGLE, FN_PULL, FN_WLATCH, FN_RDIN, FN_RDBIT, FN_RDLATCH: begin
        if (port < PORT_COUNT) begin
          ok           = 1'b1;
          clk_en[port] = 1'b1;
          case (c.func)
            FN_CFG:    mode_word[port][4*lsel +: 4] = c.nibble;
            FN_SETPIN: latch[port][lsel] = (c.value != 0);
            FN_TOGGLE: latch[port][lsel] = ~in_word[lsel];
            FN_PULL: begin
              if (c.value == 0) begin
                mode_word[port][4*lsel +: 4] = NIB_FLOAT;
              end else begin
                mode_word[port][4*lsel +: 4] = NIB_PULL;
                latch[port][lsel] = (c.value == 1);
              end
            end
            FN_WLATCH: latch[port] = c.value[15:0];
            FN_RDIN:   rd = in_word;
            FN_RDBIT:  rd = {15'b0, in_word[lsel]};
            default:   rd = latch[port];
          endcase
        end
      end
      default: ;
    endcase
    r.accepted     = ok;
    r.read_data    = ok ? rd : 16'h0;
    r.port_clocks  = 4'(clk_en);
    r.latch_levels = '0;
    for (int p = 0; p < PORT_COUNT && p < OUT_PORTS; p++) begin
      r.latch_levels[16*p +: 16] = latch[p];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("testbench: mismatch on %s at cycle %0d: got %0h, expected %0h",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] pick_value(logic [3:0] func);
    logic [31:0] v;
    v = $urandom;
    if (func == FN_SETPIN && $urandom_range(1) == 0) v = '0;
    if (func == FN_PULL && $urandom_range(3) != 0) v = $urandom_range(2);
    return v;
  endfunction

  task automatic add_random_burst();
    int unsigned port;
    int unsigned len;
    int unsigned r;
    logic [3:0]  func;
    logic [7:0]  pin;
    port = ($urandom_range(9) < 9) ? $urandom_range(3) : $urandom_range(15, 4);
    len  = $urandom_range(8, 3);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 8)       func = FN_CFG;
      else if (r < 22) func = FN_SETPIN;
      else if (r < 32) func = FN_BATCH;
      else if (r < 44) func = FN_TOGGLE;
      else if (r < 56) func = FN_PULL;
      else if (r < 64) func = FN_WLATCH;
      else if (r < 74) func = FN_RDIN;
      else if (r < 86) func = FN_RDBIT;
      else if (r < 92) func = FN_RDLATCH;
      else if (r < 95) func = FN_WNOP;
      else if (r < 97) func = FN_RNOP;
      else             func = 4'($urandom_range(15, 11));
      pin = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                     : 8'(port * 16 + $urandom_range(15));
      cmd_queue.push_back(make_cmd(func, pin, 4'($urandom), pick_value(func), $urandom,
                                   {$urandom, $urandom}));
    end
    cmd_queue.push_back(make_cmd(FN_RDLATCH, 8'(port * 16), 4'($urandom), $urandom, $urandom,
                                 {$urandom, $urandom}));
  endtask

  assign quiet = (sent_count >= n_directed + 400) && (sent_count < n_directed + 550);

  always @(negedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.func       <= '0;
      in_ch.pin        <= '0;
      in_ch.nibble     <= '0;
      in_ch.value      <= '0;
      in_ch.reset_bits <= '0;
      in_ch.pin_levels <= '0;
    end else if (in_ch.valid && !in_fire) begin
      in_ch.valid <= 1'b1;
    end else if ((sent_count == n_directed || sent_count == n_directed + 650)
                 && expected_results.size() != 0) begin
      in_ch.valid <= 1'b0;
    end else if (!quiet && !hold_off && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
    end else if (cmd_queue.size() != 0) begin
      nxt = cmd_queue.pop_front();
      in_ch.func       <= nxt.func;
      in_ch.pin        <= nxt.pin;
      in_ch.nibble     <= nxt.nibble;
      in_ch.value      <= nxt.value;
      in_ch.reset_bits <= nxt.reset_bits;
      in_ch.pin_levels <= nxt.pin_levels;
      in_ch.valid      <= 1'b1;
      sent_count++;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && (quiet || $urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    result_t want;
    item_t   seen;
    cycle_count <= cycle_count + 1;
    in_fire     <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_ch.latch_levels, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", out_ch.accepted, want.accepted);
        if (out_ch.read_data !== want.read_data)
          report_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.port_clocks !== want.port_clocks)
          report_mismatch("port_clocks", out_ch.port_clocks, want.port_clocks);
        if (out_ch.latch_levels !== want.latch_levels)
          report_mismatch("latch_levels", out_ch.latch_levels, want.latch_levels);
        results_checked++;
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen = make_cmd(in_ch.func, in_ch.pin, in_ch.nibble, in_ch.value, in_ch.reset_bits,
                      in_ch.pin_levels);
      want = predict_command(seen);
      if (!want.accepted) rejected_count++;
      expected_results.push_back(want);
      taken_count++;
    end
  end

  initial begin
    wait (rst_n && taken_count >= n_directed + 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: timed out with %0d results outstanding", expected_results.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    clk_en            = '0;
    for (int p = 0; p < PORT_COUNT; p++) begin
      mode_word[p] = MODE_RESET;
      latch[p]     = '0;
    end

    cmd_queue.push_back(make_cmd(FN_WNOP, 8'd0, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_RNOP, 8'd0, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(4'd11, 8'd0, 4'hF, '1, '1, '1));
    cmd_queue.push_back(make_cmd(4'd15, 8'd255, 4'hF, '1, '1, '1));
    cmd_queue.push_back(make_cmd(FN_CFG, 8'd0, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_CFG, 8'd63, 4'hF, '1, '1, '1));
    cmd_queue.push_back(make_cmd(FN_SETPIN, 8'd0, 4'h0, 32'd1, '0, '0));
    cmd_queue.push_back(make_cmd(FN_SETPIN, 8'd15, 4'h0, '1, '0, '0));
    cmd_queue.push_back(make_cmd(FN_SETPIN, 8'd16, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_BATCH, 8'd200, 4'h0, '1, '1, '0));
    cmd_queue.push_back(make_cmd(FN_BATCH, 8'd0, 4'h0, '0, '1, '0));
    cmd_queue.push_back(make_cmd(FN_BATCH, 8'd0, 4'h0, 32'h0000_AAAA, 32'h5555_FFFF, '0));
    cmd_queue.push_back(make_cmd(FN_TOGGLE, 8'd47, 4'h0, '0, '0, '1));
    cmd_queue.push_back(make_cmd(FN_TOGGLE, 8'd48, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_PULL, 8'd5, 4'h0, 32'd0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_PULL, 8'd6, 4'h0, 32'd1, '0, '0));
    cmd_queue.push_back(make_cmd(FN_PULL, 8'd7, 4'h0, 32'd2, '0, '0));
    cmd_queue.push_back(make_cmd(FN_PULL, 8'd8, 4'h0, '1, '0, '0));
    cmd_queue.push_back(make_cmd(FN_WLATCH, 8'd32, 4'h0, '1, '0, '0));
    cmd_queue.push_back(make_cmd(FN_WLATCH, 8'd48, 4'h0, 32'h1234_5678, '0, '0));
    cmd_queue.push_back(make_cmd(FN_RDIN, 8'd48, 4'h0, '0, '0, 64'hFFFF_0000_0000_0000));
    cmd_queue.push_back(make_cmd(FN_RDBIT, 8'd63, 4'h0, '0, '0, '1));
    cmd_queue.push_back(make_cmd(FN_RDBIT, 8'd0, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_RDLATCH, 8'd32, 4'h0, '0, '0, '0));
    cmd_queue.push_back(make_cmd(FN_SETPIN, 8'd64, 4'h0, '1, '0, '1));
    cmd_queue.push_back(make_cmd(FN_RDIN, 8'd255, 4'h0, '0, '0, '1));
    cmd_queue.push_back(make_cmd(FN_CFG, 8'd100, 4'hA, '0, '0, '0));
    n_directed = cmd_queue.size();
    while (cmd_queue.size() < n_directed + RANDOM_ITEMS) add_random_burst();
    n_total = cmd_queue.size();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    wait (taken_count == n_total);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    $display("testbench: %0d commands taken (%0d rejected), %0d results checked",
             taken_count, rejected_count, results_checked);
    $display("testbench: covered every command code, bad ports, a long output hold-off and drains");
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
